// ----- rtl/http_segment_hold_decision_core_assert.svh -----
// ----------------------------------------------------------------------------
// HTTP segment hold decision: assertion macros
// Clocked assertion wrappers used by the RTL core of this block.
// ----------------------------------------------------------------------------
`ifndef HTTP_SEGMENT_HOLD_DECISION_CORE_ASSERT_SVH
`define HTTP_SEGMENT_HOLD_DECISION_CORE_ASSERT_SVH

// check on every clock edge outside reset
`define HSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check on every clock edge, reset included
`define HSD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/hsd_pkg.sv -----
// ----------------------------------------------------------------------------
// HTTP segment hold decision package
// Widths, character codes, register indexes and payload types.
// ----------------------------------------------------------------------------
package hsd_pkg;

  // segment length counter width (8 to 32)
  localparam int LengthBits = 16;
  // result field width
  localparam int FieldBits  = 16;
  // width of the decision arithmetic: room for length + terminator + threshold
  localparam int CalcBits   = ((LengthBits > FieldBits) ? LengthBits : FieldBits) + 2;
  localparam int TermLen    = 4;

  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChLf = 8'h0A;

  typedef enum logic [1:0] {
    REG_HEADER_THRESHOLD = 2'd0,
    REG_HEADER_PARTIAL   = 2'd1,
    REG_BODY_THRESHOLD   = 2'd2,
    REG_BODY_PARTIAL     = 2'd3
  } cfg_reg_e;

  // terminator match progress
  typedef enum logic [3:0] {
    MATCH_NONE   = 4'b0001,
    MATCH_CR     = 4'b0010,
    MATCH_CRLF   = 4'b0100,
    MATCH_CRLFCR = 4'b1000
  } match_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic                 header_complete;
    logic [FieldBits-1:0] header_length;
    logic                 header_hold;
    logic [FieldBits-1:0] header_release;
    logic                 body_hold;
    logic [FieldBits-1:0] body_release;
    logic                 length_overflow;
  } out_item_t;

  typedef struct packed {
    logic [FieldBits-1:0] header_threshold;
    logic                 header_partial;
    logic [FieldBits-1:0] body_threshold;
    logic                 body_partial;
  } cfg_t;

  // segment state as seen after the current byte
  typedef struct packed {
    logic                  found;
    logic [LengthBits-1:0] offset;
    logic [LengthBits-1:0] count;
    logic                  saturated;
  } seg_t;

endpackage

// ----- rtl/http_segment_hold_decision_core.sv -----
// ----------------------------------------------------------------------------
// HTTP segment hold decision core
// Flow: input register, then result register for the decision on a last byte.
// Throughput: one byte per cycle; the input register drains every cycle unless
//   a last byte finds the result register full and stalled.
// Reset: asynchronous active low; clears config, segment state and both valids.
// ----------------------------------------------------------------------------
`include "http_segment_hold_decision_core_assert.svh"

module http_segment_hold_decision_core import hsd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // config writes, only while idle
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [FieldBits-1:0] cfg_data_i,
  // byte stream
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_item_i,
  // decisions
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_item_o
);

  cfg_t      cfg_q;
  logic      in_valid_q;
  in_item_t  in_q;
  logic      out_valid_q;
  out_item_t out_q;

  logic      in_take, in_fire, out_free, res_load;
  seg_t      seg;
  out_item_t res;

  // Config registers. Thresholds and partial bits go straight into the decision
  // logic; the user must change values only with the pipe empty (not enforced).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_HEADER_THRESHOLD: cfg_q.header_threshold <= cfg_data_i;
        REG_HEADER_PARTIAL:   cfg_q.header_partial   <= cfg_data_i[0];
        REG_BODY_THRESHOLD:   cfg_q.body_threshold   <= cfg_data_i;
        REG_BODY_PARTIAL:     cfg_q.body_partial     <= cfg_data_i[0];
        default:              cfg_q                  <= cfg_q;
      endcase
    end
  end

  // Handshake. A byte in the input register moves on each cycle; a last
  // byte also needs room in the result register, which frees up when its
  // transfer completes in the same cycle.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_fire    = in_valid_q && (!in_q.last_byte || out_free);
  assign res_load   = in_fire && in_q.last_byte;
  assign in_stall_o = in_valid_q && !in_fire;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_take || (in_valid_q && !in_fire);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_item_i;
    end
  end

  // Segment state: steps on every byte that leaves the input register and
  // clears after the last byte of a segment.
  hsd_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (in_q.data_byte),
    .step_i  (in_fire),
    .clear_i (in_q.last_byte),
    .seg_o   (seg)
  );

  // Decisions from the state that includes the last byte.
  hsd_decide u_decide (
    .seg_i (seg),
    .cfg_i (cfg_q),
    .res_o (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // a last byte that moves on always leaves a result behind
  `HSD_ASSERT(a_last_gives_result, res_load |=> out_valid_q,
              "last byte lost its result")
  // a byte that is not last never makes a result appear
  `HSD_ASSERT(a_no_spurious_result, (!out_valid_q && !res_load) |=> !out_valid_q,
              "result without last byte")
  // header hold needs a complete header; releases only under a hold
  `HSD_ASSERT(a_header_hold_consistent,
              out_valid_q |-> ((!out_q.header_hold || out_q.header_complete) &&
                               (out_q.header_release == '0 || out_q.header_hold)),
              "header hold inconsistent")
  `HSD_ASSERT(a_body_release_needs_hold,
              out_valid_q |-> (out_q.body_release == '0 || out_q.body_hold),
              "body release without hold")
  `HSD_ASSERT_ALWAYS(a_reset_no_output, !rst_ni |-> (!out_valid_o && !in_stall_o),
                     "active output in reset")

endmodule

// ----- rtl/hsd_scan.sv -----
// ----------------------------------------------------------------------------
// HTTP segment scanner
// Per-byte terminator match and saturating length count.
// ----------------------------------------------------------------------------
module hsd_scan import hsd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] byte_i,
  input  logic       step_i,
  input  logic       clear_i,
  output seg_t       seg_o
);

  localparam logic [LengthBits-1:0] LenMax = {LengthBits{1'b1}};
  localparam logic [LengthBits-1:0] Back   = LengthBits'(TermLen - 1);

  match_e                match_q, match_d;
  logic                  found_q, found_d;
  logic [LengthBits-1:0] offset_q, offset_d;
  logic [LengthBits-1:0] count_q, count_d;
  logic                  sat_q, sat_d;
  logic                  is_cr, is_lf;

  assign is_cr = (byte_i == ChCr);
  assign is_lf = (byte_i == ChLf);

  always_comb begin
    match_d  = match_q;
    found_d  = found_q;
    offset_d = offset_q;
    if (!found_q) begin
      case (match_q)
        MATCH_NONE:   match_d = is_cr ? MATCH_CR : MATCH_NONE;
        MATCH_CR:     match_d = is_lf ? MATCH_CRLF : (is_cr ? MATCH_CR : MATCH_NONE);
        MATCH_CRLF:   match_d = is_cr ? MATCH_CRLFCR : MATCH_NONE;
        MATCH_CRLFCR: begin
          if (is_lf) begin
            found_d  = 1'b1;
            offset_d = (count_q >= Back) ? (count_q - Back) : '0;
            match_d  = MATCH_NONE;
          end else begin
            match_d = is_cr ? MATCH_CR : MATCH_NONE;
          end
        end
        default:      match_d = MATCH_NONE;
      endcase
    end
  end

  // counter stops at all ones and flags the overflow
  always_comb begin
    count_d = count_q;
    sat_d   = sat_q;
    if (count_q == LenMax) begin
      sat_d = 1'b1;
    end else begin
      count_d = count_q + LengthBits'(1);
    end
  end

  assign seg_o = '{found: found_d, offset: offset_d, count: count_d, saturated: sat_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q  <= MATCH_NONE;
      found_q  <= 1'b0;
      offset_q <= '0;
      count_q  <= '0;
      sat_q    <= 1'b0;
    end else if (step_i) begin
      if (clear_i) begin
        match_q  <= MATCH_NONE;
        found_q  <= 1'b0;
        offset_q <= '0;
        count_q  <= '0;
        sat_q    <= 1'b0;
      end else begin
        match_q  <= match_d;
        found_q  <= found_d;
        offset_q <= offset_d;
        count_q  <= count_d;
        sat_q    <= sat_d;
      end
    end
  end

endmodule

// ----- rtl/hsd_decide.sv -----
// ----------------------------------------------------------------------------
// HTTP segment hold decision logic
// Header and body hold rules on the final segment state.
// ----------------------------------------------------------------------------
module hsd_decide import hsd_pkg::*; (
  input  seg_t      seg_i,
  input  cfg_t      cfg_i,
  output out_item_t res_o
);

  logic [CalcBits-1:0] n, hlen, hthr, bthr, hdr, body, rsum;
  logic [CalcBits-1:0] hrel, brel;
  logic                hhold, bhold;

  assign n    = CalcBits'(seg_i.count);
  assign hlen = seg_i.found ? CalcBits'(seg_i.offset) : n;
  assign hthr = CalcBits'(cfg_i.header_threshold);
  assign bthr = CalcBits'(cfg_i.body_threshold);

  assign hhold = (hthr != '0) && seg_i.found && (hlen >= hthr);
  assign hrel  = (hhold && cfg_i.header_partial) ? ((hthr < n) ? hthr : n) : '0;

  // no terminator: the whole segment counts as body
  assign hdr  = seg_i.found ? (hlen + CalcBits'(TermLen)) : '0;
  assign body = (n >= hdr) ? (n - hdr) : '0;
  assign rsum = hdr + bthr;

  assign bhold = (bthr != '0) && (body >= bthr);
  assign brel  = (bhold && cfg_i.body_partial) ? ((rsum < n) ? rsum : n) : '0;

  assign res_o = '{
    header_complete: seg_i.found,
    header_length:   hlen[FieldBits-1:0],
    header_hold:     hhold,
    header_release:  hrel[FieldBits-1:0],
    body_hold:       bhold,
    body_release:    brel[FieldBits-1:0],
    length_overflow: seg_i.saturated
  };

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP segment hold decision testbench
// Streams HTTP-like byte segments into the core under random idling and
// back-pressure. A scoreboard class predicts the per-segment hold decision
// and checks every decision transfer field by field.
// ----------------------------------------------------------------------------
import hsd_pkg::*;

class decision_scoreboard;
  // configuration copy
  logic [FieldBits-1:0]  hdr_thresh;
  logic                  hdr_partial;
  logic [FieldBits-1:0]  body_thresh;
  logic                  body_partial;
  // segment state
  logic [LengthBits-1:0] seg_count;
  logic [LengthBits-1:0] term_offset;
  logic                  term_seen;
  logic                  seg_saturated;
  match_e                term_match;

  out_item_t             expected_decisions[$];
  int unsigned           mismatches;

  function new();
    hdr_thresh   = '0;
    hdr_partial  = 1'b0;
    body_thresh  = '0;
    body_partial = 1'b0;
    mismatches   = 0;
    clear_segment();
  endfunction

  function void clear_segment();
    seg_count     = '0;
    term_offset   = '0;
    term_seen     = 1'b0;
    seg_saturated = 1'b0;
    term_match    = MATCH_NONE;
  endfunction

  function void set_reg(cfg_reg_e idx, logic [FieldBits-1:0] value);
    case (idx)
      REG_HEADER_THRESHOLD: hdr_thresh   = value;
      REG_HEADER_PARTIAL:   hdr_partial  = value[0];
      REG_BODY_THRESHOLD:   body_thresh  = value;
      REG_BODY_PARTIAL:     body_partial = value[0];
      default: ;
    endcase
  endfunction

  function int unsigned pending();
    return expected_decisions.size();
  endfunction

  // decision for the segment that just ended
  function out_item_t predict_decision();
    out_item_t r;
    longint unsigned n, hlen, hdr, body, rel;
    n    = seg_count;
    hlen = term_seen ? longint'(term_offset) : n;
    r    = '0;
    r.header_complete = term_seen;
    r.header_length   = FieldBits'(hlen);
    r.length_overflow = seg_saturated;
    if (hdr_thresh != 0 && term_seen && hlen >= hdr_thresh) begin
      r.header_hold = 1'b1;
      if (hdr_partial) r.header_release = FieldBits'((hdr_thresh < n) ? hdr_thresh : n);
    end
    if (term_seen) begin
      hdr  = hlen + TermLen;
      body = (n >= hdr) ? n - hdr : 0;
    end else begin
      hdr  = 0;
      body = n;
    end
    if (body_thresh != 0 && body >= body_thresh) begin
      r.body_hold = 1'b1;
      if (body_partial) begin
        rel = hdr + body_thresh;
        r.body_release = FieldBits'((rel < n) ? rel : n);
      end
    end
    return r;
  endfunction

  function void note_input(in_item_t item);
    logic [LengthBits-1:0] idx;
    idx = seg_count;
    // CR LF CR LF search, frozen once the first terminator is found
    if (!term_seen) begin
      case (term_match)
        MATCH_NONE:
          term_match = (item.data_byte == ChCr) ? MATCH_CR : MATCH_NONE;
        MATCH_CR:
          term_match = (item.data_byte == ChLf) ? MATCH_CRLF :
                       (item.data_byte == ChCr) ? MATCH_CR : MATCH_NONE;
        MATCH_CRLF:
          term_match = (item.data_byte == ChCr) ? MATCH_CRLFCR : MATCH_NONE;
        default: begin
          if (item.data_byte == ChLf) begin
            term_seen   = 1'b1;
            term_offset = (idx >= 3) ? LengthBits'(idx - 3) : '0;
            term_match  = MATCH_NONE;
          end else begin
            term_match = (item.data_byte == ChCr) ? MATCH_CR : MATCH_NONE;
          end
        end
      endcase
    end
    if (seg_count == {LengthBits{1'b1}}) seg_saturated = 1'b1;
    else seg_count++;
    if (item.last_byte) begin
      expected_decisions.push_back(predict_decision());
      clear_segment();
    end
  endfunction

  function void compare_field(string name, logic [FieldBits-1:0] want,
                              logic [FieldBits-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function void check_result(out_item_t got);
    out_item_t want;
    if (expected_decisions.size() == 0) begin
      $error("decision transfer with no segment pending");
      mismatches++;
      return;
    end
    want = expected_decisions.pop_front();
    compare_field("header_complete", FieldBits'(want.header_complete),
                  FieldBits'(got.header_complete));
    compare_field("header_length", want.header_length, got.header_length);
    compare_field("header_hold", FieldBits'(want.header_hold), FieldBits'(got.header_hold));
    compare_field("header_release", want.header_release, got.header_release);
    compare_field("body_hold", FieldBits'(want.body_hold), FieldBits'(got.body_hold));
    compare_field("body_release", want.body_release, got.body_release);
    compare_field("length_overflow", FieldBits'(want.length_overflow),
                  FieldBits'(got.length_overflow));
  endfunction
endclass

module tb;
  localparam int unsigned HoldOffCycles = 300;    // long receiver hold-off
  localparam int unsigned RandomBytes   = 380;    // minimum bytes in the random part
  localparam int unsigned MinDecisions  = 20;     // minimum segments in the random part
  localparam int unsigned LimitNs       = 2_000_000;

  logic                 clk      = 1'b0;
  logic                 rst_n    = 1'b0;
  logic                 cfg_we   = 1'b0;
  logic [1:0]           cfg_idx  = '0;
  logic [FieldBits-1:0] cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_item  = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_item;

  decision_scoreboard   board = new();

  // idling controls, written only by the stimulus process
  bit                   tx_gaps = 1'b0;
  bit                   rx_gaps = 1'b0;
  int unsigned          hold_off_requests = 0;

  int unsigned          bytes_sent    = 0;
  int unsigned          segments_sent = 0;
  logic [7:0]           seg_q[$];

  http_segment_hold_decision_core uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop: far above the slowest legal run (some 700 bytes with worst-case
  // gaps on both sides and one long receiver hold-off).
  initial begin
    #(LimitNs);
    $display("FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver side. Stall changes only at the falling edge. A hold-off request
  // from the stimulus process is served here by a local cycle counter, so the
  // sender keeps offering bytes while decisions back up into the core.
  // --------------------------------------------------------------------------
  int unsigned hold_off_served = 0;
  int unsigned hold_off_left   = 0;
  int unsigned rx_burst_left   = 0;
  bit          rx_burst_stall  = 1'b0;

  always @(negedge clk) begin
    if (hold_off_served != hold_off_requests) begin
      hold_off_served = hold_off_requests;
      hold_off_left   = HoldOffCycles;
    end
    if (hold_off_left != 0) begin
      hold_off_left--;
      out_stall <= 1'b1;
    end else if (!rx_gaps) begin
      out_stall <= 1'b0;
    end else begin
      // alternate random-length stall bursts with free runs
      if (rx_burst_left == 0) begin
        rx_burst_stall = ($urandom_range(0, 2) == 0);
        rx_burst_left  = rx_burst_stall ? $urandom_range(1, 5) : $urandom_range(1, 8);
      end
      rx_burst_left--;
      out_stall <= rx_burst_stall;
    end
  end

  // A decision transfer happens at a rising edge with valid high, stall low.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_item);
  end

  // --------------------------------------------------------------------------
  // Sender side. Called at a falling edge, returns at a falling edge with the
  // transferred byte still on the bus; the next call either replaces it or
  // opens a gap first.
  // --------------------------------------------------------------------------
  task automatic send_byte(logic [7:0] data, logic last);
    in_item_t item;
    item.data_byte = data;
    item.last_byte = last;
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    do @(posedge clk); while (in_stall);
    board.note_input(item);
    bytes_sent++;
    @(negedge clk);
  endtask

  // send the queued segment, flagging its final byte
  task automatic send_segment();
    foreach (seg_q[i]) send_byte(seg_q[i], i == seg_q.size() - 1);
    seg_q.delete();
    segments_sent++;
  endtask

  // '^' stands for CR and '~' for LF
  function automatic void append_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      case (s[i])
        "^":     seg_q.push_back(ChCr);
        "~":     seg_q.push_back(ChLf);
        default: seg_q.push_back(s[i]);
      endcase
    end
  endfunction

  // mostly text, sometimes any byte, CR or LF with the given percentage
  function automatic logic [7:0] line_byte(int unsigned crlf_pct);
    if ($urandom_range(0, 99) < crlf_pct) return $urandom_range(0, 1) ? ChCr : ChLf;
    if ($urandom_range(0, 1)) return 8'($urandom_range(32, 126));
    return 8'($urandom_range(0, 255));
  endfunction

  // thresholds: off, one, the maximum, or near the segment sizes used
  function automatic logic [FieldBits-1:0] pick_threshold();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return FieldBits'(1);
      2:       return '1;
      default: return FieldBits'($urandom_range(1, 24));
    endcase
  endfunction

  task automatic build_random_segment(int unsigned max_part);
    int unsigned kind, n;
    kind = $urandom_range(0, 9);
    n    = $urandom_range(0, max_part);
    if (kind <= 6) begin
      // well-formed: header, terminator, body
      repeat (n) seg_q.push_back(line_byte(8));
      append_text("^~^~");
      repeat ($urandom_range(0, max_part)) seg_q.push_back(line_byte(5));
    end else if (kind == 7) begin
      // CR/LF heavy noise
      repeat (n + 1) seg_q.push_back(line_byte(50));
    end else if (kind == 8) begin
      // header with a broken terminator
      repeat (n) seg_q.push_back(line_byte(8));
      case ($urandom_range(0, 2))
        0:       append_text("^~^x");
        1:       append_text("^~~");
        default: append_text("^^~^");
      endcase
      repeat ($urandom_range(0, 4)) seg_q.push_back(line_byte(20));
    end else begin
      // no CR or LF on purpose; only the any-byte draws can give one
      repeat (n + 1) seg_q.push_back(line_byte(0));
    end
  endtask

  task automatic send_directed();
    string texts[6];
    texts = '{"Z", "^~^~", "ab^~^~cd", "^^~^~", "^~^^~^~x", "x^~^~y^~^~"};
    // extreme byte values
    seg_q.push_back(8'h00);
    seg_q.push_back(8'hFF);
    send_segment();
    foreach (texts[i]) begin
      append_text(texts[i]);
      send_segment();
    end
  endtask

  // idle the input, wait for all decisions, then let the pipe empty
  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // writes all four registers back to back; partial flags get random upper bits
  task automatic apply_config(logic [FieldBits-1:0] h_thr, logic h_part,
                              logic [FieldBits-1:0] b_thr, logic b_part);
    cfg_reg_e             regs[4];
    logic [FieldBits-1:0] vals[4];
    regs    = '{REG_HEADER_THRESHOLD, REG_HEADER_PARTIAL, REG_BODY_THRESHOLD, REG_BODY_PARTIAL};
    vals[0] = h_thr;
    vals[1] = FieldBits'($urandom);
    vals[1][0] = h_part;
    vals[2] = b_thr;
    vals[3] = FieldBits'($urandom);
    vals[3][0] = b_part;
    foreach (regs[i]) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= regs[i];
      cfg_data <= vals[i];
      @(negedge clk);
      board.set_reg(regs[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned phase, bytes_start, segs_start;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;

    // directed: reset configuration (both rules off), then low thresholds
    send_directed();
    settle();
    apply_config(FieldBits'(2), 1'b1, FieldBits'(1), 1'b1);
    send_directed();
    settle();

    // random phases, one configuration each; one phase runs the long hold-off
    phase       = 0;
    bytes_start = bytes_sent;
    segs_start  = segments_sent;
    while (bytes_sent - bytes_start < RandomBytes ||
           segments_sent - segs_start < MinDecisions) begin
      apply_config(pick_threshold(), 1'($urandom_range(0, 1)),
                   pick_threshold(), 1'($urandom_range(0, 1)));
      if (phase == 1) begin
        hold_off_requests++;
        repeat (24) begin
          build_random_segment(3);
          send_segment();
        end
      end
      repeat (8) begin
        build_random_segment(20);
        send_segment();
      end
      settle();
      phase++;
    end

    // last part, no idling: back-to-back bytes and decisions
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    apply_config(FieldBits'(3), 1'b1, FieldBits'(2), 1'b1);
    append_text("ab^~^~c");
    send_segment();
    repeat (6) begin
      build_random_segment(20);
      send_segment();
    end
    settle();

    if (board.mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+rtl
rtl/hsd_pkg.sv
rtl/hsd_scan.sv
rtl/hsd_decide.sv
rtl/http_segment_hold_decision_core.sv
sim/tb.sv
